// ===== src/nearest_point_distance_3d_assert.svh =====
`ifndef NEAREST_POINT_DISTANCE_3D_ASSERT_SVH
`define NEAREST_POINT_DISTANCE_3D_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define NPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_point_distance_3d: assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define NPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_point_distance_3d: assertion failed");

`endif

// ===== src/npd_pkg.sv =====
package npd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int ROOT_W      = COORD_WIDTH + 1;
    localparam int SUM_W       = 2 * ROOT_W;
    localparam int DIST_W      = 25;
    localparam int CFG_INDEX_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_REF_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          first_of_set;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [DIST_W-1:0] smallest_so_far;
    } out_item_t;

endpackage

// ===== src/nearest_point_distance_3d.sv =====
// A request passes through the shared squarer and accumulator (S_SQUARE), then the
// one-bit-per-cycle square root (S_ROOT), and retires to the output register (S_DONE);
// a new request is taken only once the previous result has been loaded.
// The result register frees the input side as soon as the result is loaded.
// Reset (rst_n low, asynchronous) clears the reference point, the running minimum
// and its valid flag, and returns the sequencer to idle.
`include "nearest_point_distance_3d_assert.svh"

module nearest_point_distance_3d
    import npd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int EXT_W = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [COORD_WIDTH-1:0]   ref_x_reg;
    logic [COORD_WIDTH-1:0]   ref_y_reg;
    logic [COORD_WIDTH-1:0]   ref_z_reg;
    logic [COORD_WIDTH-1:0]   pt_x_reg;
    logic [COORD_WIDTH-1:0]   pt_y_reg;
    logic [COORD_WIDTH-1:0]   pt_z_reg;
    logic                     first_reg;
    logic [SUM_W-1:0]         prod_reg;
    logic [SUM_W-1:0]         acc_reg;
    logic [ROOT_W-1:0]        rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [DIST_W-1:0]        running_min_reg;
    logic                     min_valid_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic [COORD_WIDTH-1:0]   sel_ref;
    logic [COORD_WIDTH-1:0]   sel_pt;
    logic [DIFF_W-1:0]        diff;
    logic [DIFF_W-1:0]        mag;
    logic [SUM_W-1:0]         square;
    logic [ROOT_W+1:0]        rem_shift;
    logic [ROOT_W+1:0]        trial;
    logic [ROOT_W+1:0]        rem_sub;
    logic                     take_bit;
    logic [ROOT_W-1:0]        rem_next;
    logic [ROOT_W-1:0]        root_next;
    logic [EXT_W-1:0]         root_ext;
    logic [DIST_W-1:0]        dist_val;
    logic                     start_set;
    logic [DIST_W-1:0]        min_next;

    // Shared squarer: the counter picks which axis goes through it this cycle.
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                sel_ref = ref_x_reg;
                sel_pt  = pt_x_reg;
            end
            2'd1:
            begin
                sel_ref = ref_y_reg;
                sel_pt  = pt_y_reg;
            end
            2'd2:
            begin
                sel_ref = ref_z_reg;
                sel_pt  = pt_z_reg;
            end
            default:
            begin
                sel_ref = '0;
                sel_pt  = '0;
            end
        endcase
    end

    // The magnitude of the most negative difference wraps to the right unsigned value.
    assign diff   = {sel_pt[COORD_WIDTH-1], sel_pt} - {sel_ref[COORD_WIDTH-1], sel_ref};
    assign mag    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    assign square = SUM_W'(mag) * SUM_W'(mag);

    // Restoring square root, one result bit per cycle; the radicand is shifted out
    // of the top of the accumulator two bits at a time.
    assign rem_shift = {rem_reg, acc_reg[SUM_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign rem_sub   = rem_shift - trial;
    assign take_bit  = (rem_shift >= trial);
    assign rem_next  = take_bit ? rem_sub[ROOT_W-1:0] : rem_shift[ROOT_W-1:0];
    assign root_next = {root_reg[ROOT_W-2:0], take_bit};

    assign root_ext  = EXT_W'(root_reg);
    assign dist_val  = (root_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];
    assign start_set = first_reg || !min_valid_reg;
    assign min_next  = (start_set || (dist_val < running_min_reg)) ? dist_val : running_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            ref_x_reg       <= '0;
            ref_y_reg       <= '0;
            ref_z_reg       <= '0;
            pt_x_reg        <= '0;
            pt_y_reg        <= '0;
            pt_z_reg        <= '0;
            first_reg       <= 1'b0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            rem_reg         <= '0;
            root_reg        <= '0;
            running_min_reg <= '0;
            min_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_REF_X:
                    begin
                        ref_x_reg <= cfg_data;
                    end
                    REG_REF_Y:
                    begin
                        ref_y_reg <= cfg_data;
                    end
                    REG_REF_Z:
                    begin
                        ref_z_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // A result loaded this cycle takes the place of the one leaving.
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pt_x_reg  <= in_data.point_x;
                        pt_y_reg  <= in_data.point_y;
                        pt_z_reg  <= in_data.point_z;
                        first_reg <= in_data.first_of_set;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    // The product of one axis is added while the next axis is squared.
                    if (cnt_reg != CNT_W'(3))
                    begin
                        prod_reg <= square;
                    end
                    if (cnt_reg != '0)
                    begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    if (cnt_reg == CNT_W'(3))
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_ROOT:
                begin
                    acc_reg  <= {acc_reg[SUM_W-3:0], 2'b00};
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    if (cnt_reg == CNT_W'(ROOT_W - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.distance        <= dist_val;
                        out_data_reg.smallest_so_far <= min_next;
                        running_min_reg              <= min_next;
                        min_valid_reg                <= 1'b1;
                        state_reg                    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    `NPD_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
    `NPD_ASSERT_NOW(a_min_not_above_dist, out_valid,
        out_data.smallest_so_far <= out_data.distance)
    `NPD_ASSERT_NEXT(a_min_valid_sticks, min_valid_reg, min_valid_reg)
    `NPD_ASSERT_NOW(a_result_only_when_free, (state_reg == S_DONE) && out_valid && out_stall,
        $stable(out_data))

endmodule
